>>> rtl/sti_pkg.sv
package sti_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned StatW   = 2;
  localparam int unsigned FillW   = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 48;
  // read path: groups of eight cells, picked in two registered steps
  localparam int unsigned GrpSize = 8;
  localparam int unsigned NumGrp  = 8;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } dp_cmd_t;

endpackage

>>> rtl/sti_ctrl.sv
module sti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sti_pkg::dp_cmd_t  cmd_o
);

  sti_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sti_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      sti_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = sti_pkg::S_CMP;
        end
      end
      sti_pkg::S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = sti_pkg::S_UPD;
      end
      sti_pkg::S_UPD: begin
        // result register takes the new item only once the old one is gone
        if (out_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          in_ready_o   = 1'b1;
          state_d      = in_valid_i ? sti_pkg::S_CMP : sti_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sti_pkg::S_IDLE;
      end
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/sti_datapath.sv
module sti_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sti_pkg::dp_cmd_t                    cmd_i,
  input  logic [sti_pkg::OpW-1:0]             op_i,
  input  logic signed [sti_pkg::KeyW-1:0]     key_i,
  input  logic [sti_pkg::IdxW-1:0]            read_index_i,
  output logic [sti_pkg::StatW-1:0]           status_o,
  output logic [sti_pkg::FillW-1:0]           fill_count_o,
  output logic [sti_pkg::PosW-1:0]            position_o,
  output logic signed [sti_pkg::KeyW-1:0]     read_value_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned XW = (CW > sti_pkg::IdxW) ? CW : sti_pkg::IdxW;

  // item registers
  sti_pkg::op_e                     op_q;
  logic signed [sti_pkg::KeyW-1:0]  key_q;
  logic [sti_pkg::IdxW-1:0]         ridx_q;

  // table cells and fill count
  logic signed [sti_pkg::KeyW-1:0]  cell_q [DEPTH];
  logic signed [sti_pkg::KeyW-1:0]  cell_d [DEPTH];
  logic signed [sti_pkg::KeyW-1:0]  prv    [DEPTH];
  logic signed [sti_pkg::KeyW-1:0]  nxt    [DEPTH];
  logic [CW-1:0]                    count_q, count_d;

  // per-cell compare flags and read group picks
  logic [DEPTH-1:0]                 le_q, le_d, lt_q, lt_d;
  logic [DEPTH-1:0]                 le_sh, lt_sh, ins_hot, del_hot;
  logic signed [sti_pkg::KeyW-1:0]  grp_q [sti_pkg::NumGrp];
  logic signed [sti_pkg::KeyW-1:0]  grp_d [sti_pkg::NumGrp];

  // result register
  sti_pkg::status_e                 status_q, status_d;
  logic [sti_pkg::FillW-1:0]        fill_q;
  logic [sti_pkg::PosW-1:0]         pos_q, pos_d;
  logic signed [sti_pkg::KeyW-1:0]  value_q, value_d;

  logic          full, found, do_ins, do_del, rd_ok;
  logic [PW-1:0] ins_pos, del_pos;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= sti_pkg::op_e'(op_i);
      key_q  <= key_i;
      ridx_q <= read_index_i;
    end
    if (cmd_i.compare) begin
      le_q  <= le_d;
      lt_q  <= lt_d;
      grp_q <= grp_d;
    end
    if (cmd_i.update) begin
      status_q <= status_d;
      fill_q   <= sti_pkg::FillW'(count_d);
      pos_q    <= pos_d;
      value_q  <= value_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        cell_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      count_q <= count_d;
      cell_q  <= cell_d;
    end
  end

  // compare step: every valid cell against the key, and the read group picks
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le_d[i] = (CW'(i) < count_q) && (cell_q[i] <= key_q);
      lt_d[i] = (CW'(i) < count_q) && (cell_q[i] < key_q);
    end
    for (int g = 0; g < sti_pkg::NumGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < sti_pkg::GrpSize; k++) begin
        if ((g * sti_pkg::GrpSize + k < DEPTH) && (ridx_q[2:0] == 3'(k))) begin
          grp_d[g] = cell_q[g * sti_pkg::GrpSize + k];
        end
      end
    end
  end

  // flags form thermometer codes, so their edges are one-hot positions
  assign le_sh   = {le_q[DEPTH-2:0], 1'b1};
  assign lt_sh   = {lt_q[DEPTH-2:0], 1'b1};
  assign ins_hot = ~le_q & le_sh;
  assign del_hot = le_q & ~lt_q & lt_sh;

  always_comb begin
    ins_pos = '0;
    del_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_hot[i]) begin
        ins_pos = ins_pos | PW'(i);
      end
      if (del_hot[i]) begin
        del_pos = del_pos | PW'(i);
      end
    end
  end

  assign full   = (count_q >= CW'(DEPTH));
  assign found  = |del_hot;
  assign do_ins = (op_q == sti_pkg::OP_INSERT) && !full;
  assign do_del = (op_q == sti_pkg::OP_DELETE) && found;
  assign rd_ok  = (XW'(ridx_q) < XW'(count_q));

  // update step: each cell keeps, takes its neighbor, or takes the key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prv[i] = key_q;
      nxt[i] = '0;
      if (i > 0) begin
        prv[i] = cell_q[i-1];
      end
      if (i < DEPTH - 1) begin
        nxt[i] = cell_q[i+1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      cell_d[i] = cell_q[i];
      if (do_ins && !le_q[i]) begin
        cell_d[i] = le_sh[i] ? key_q : prv[i];
      end
      if (do_del && !lt_q[i]) begin
        cell_d[i] = nxt[i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = sti_pkg::ST_OK;
    pos_d    = '0;
    value_d  = '0;
    case (op_q)
      sti_pkg::OP_INSERT: begin
        if (full) begin
          status_d = sti_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
          pos_d   = sti_pkg::PosW'(ins_pos);
        end
      end
      sti_pkg::OP_DELETE: begin
        if (found) begin
          count_d = count_q - CW'(1);
          pos_d   = sti_pkg::PosW'(del_pos);
        end else begin
          status_d = sti_pkg::ST_NOT_FOUND;
        end
      end
      sti_pkg::OP_READ: begin
        pos_d = ridx_q;
        if (rd_ok) begin
          value_d = grp_q[ridx_q[5:3]];
        end else begin
          status_d = sti_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        status_d = sti_pkg::ST_OK;
      end
    endcase
  end

  assign status_o     = status_q;
  assign fill_count_o = fill_q;
  assign position_o   = pos_q;
  assign read_value_o = value_q;

endmodule

>>> rtl/sorted_table_insert_delete_core.sv
// Sorted table of signed 32-bit keys kept in ascending order in a row of DEPTH
// register cells with a fill count; the table is empty after reset. Insert places
// the key after any equal keys (status full when DEPTH entries are held), delete
// removes the first equal key and closes the gap (status not found otherwise),
// read returns the entry at read_index (status bad index at or beyond the count);
// op code 3 does nothing and answers ok. An item goes through a compare step, in
// which every cell compares itself with the key, and then an update step, in which
// every cell shifts or holds and the result register is written. While results are
// taken as they appear, a new item is taken in the update step of the one before;
// a result not yet taken holds the next item at its update step.
module sorted_table_insert_delete_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // key[31:0], read_index[37:32], zero fill
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], fill_count[8:2], position[14:9],
                                     // read_value[46:15], zero fill
);

  sti_pkg::dp_cmd_t                        cmd;
  logic [sti_pkg::StatW-1:0]               status;
  logic [sti_pkg::FillW-1:0]               fill_count;
  logic [sti_pkg::PosW-1:0]                position;
  logic signed [sti_pkg::KeyW-1:0]         read_value;

  sti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sti_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (s_axis_tuser),
    .key_i        (s_axis_tdata[31:0]),
    .read_index_i (s_axis_tdata[37:32]),
    .status_o     (status),
    .fill_count_o (fill_count),
    .position_o   (position),
    .read_value_o (read_value)
  );

  assign m_axis_tdata = {1'b0, read_value, position, fill_count, status};

endmodule

>>> rtl/sti_checker.sv
module sti_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic [1:0]  status;
  logic [6:0]  fill_count;
  logic [5:0]  position;
  logic [31:0] read_value;

  assign status     = m_axis_tdata[1:0];
  assign fill_count = m_axis_tdata[8:2];
  assign position   = m_axis_tdata[14:9];
  assign read_value = m_axis_tdata[46:15];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == sti_pkg::ST_FULL |->
      fill_count == 7'(DEPTH) && position == 6'd0 && read_value == 32'd0)
    else $error("full status with wrong count or position");

  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == sti_pkg::ST_NOT_FOUND |->
      position == 6'd0 && read_value == 32'd0)
    else $error("not found status with nonzero fields");

  a_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == sti_pkg::ST_BAD_INDEX |->
      read_value == 32'd0 && {1'b0, position} >= fill_count)
    else $error("bad index status inside the table");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && DEPTH < 128 |-> fill_count <= 7'(DEPTH))
    else $error("fill count beyond depth");

endmodule

bind sorted_table_insert_delete_core sti_checker #(
  .DEPTH (DEPTH)
) u_sti_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
